// ----- hw/rtl/wsrd_pkg.sv -----
package wsrd_pkg;

   localparam logic [7:0]  RADIX         = 8'hFD;
   localparam logic [7:0]  PAIR_FIRST    = 8'hFE;
   localparam logic [7:0]  PAIR_SECOND   = 8'hFD;
   localparam logic [15:0] MAX_FIRST_RUN = 16'd252;
   localparam logic [15:0] MAX_LATER_RUN = 16'd64008;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_TRUNC = 2'd1;
   localparam logic [1:0] ERR_SIZE  = 2'd2;

   // results per request, at most
   localparam int MAX_RES = 3;

   typedef logic [1:0] res_cnt_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [1:0] code;
      logic       last;
   } res_type;

   function automatic res_type mk_res(logic [7:0] data, logic [1:0] kind, logic [1:0] code);
      res_type r;
      r.data = data;
      r.kind = kind;
      r.code = code;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

// ----- hw/rtl/wsrd_decode.sv -----
module wsrd_decode import wsrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_record,
   output res_type [MAX_RES-1:0] res,
   output res_cnt_type           res_cnt
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_LO,
      PH_HI,
      PH_RUN,
      PH_DROP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  low_ff, low_in;
   logic        short_ff, short_in;

   logic [15:0] run_len;
   logic [15:0] run_max;
   logic [15:0] rem_dec;
   logic        do_clear;
   res_type     r0, r1, r2;
   res_cnt_type cnt;

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      short_in = short_ff;
      do_clear = 1'b0;
      cnt      = 2'd0;
      r0       = '0;
      r1       = '0;
      r2       = '0;
      run_len  = (phase_ff == PH_HI) ? ({8'd0, low_ff} + 16'(in_byte) * 16'(RADIX))
                                     : {8'd0, in_byte};
      run_max  = (phase_ff == PH_HI) ? MAX_LATER_RUN : MAX_FIRST_RUN;
      rem_dec  = rem_ff - 16'd1;

      case (phase_ff)
         PH_FIRST, PH_HI: begin
            if (run_len > run_max) begin
               r0  = mk_res(8'd0, KIND_ERR, ERR_SIZE);
               cnt = 2'd1;
               if (end_of_record) do_clear = 1'b1;
               else phase_in = PH_DROP;
            end else begin
               short_in = (run_len < run_max);
               if (run_len == 16'd0) begin
                  if (end_of_record) begin
                     r0       = mk_res(8'd0, KIND_DONE, ERR_NONE);
                     cnt      = 2'd1;
                     do_clear = 1'b1;
                  end else begin
                     r0       = mk_res(PAIR_FIRST, KIND_DATA, ERR_NONE);
                     r1       = mk_res(PAIR_SECOND, KIND_DATA, ERR_NONE);
                     cnt      = 2'd2;
                     phase_in = PH_LO;
                  end
               end else if (end_of_record) begin
                  r0       = mk_res(8'd0, KIND_ERR, ERR_TRUNC);
                  cnt      = 2'd1;
                  do_clear = 1'b1;
               end else begin
                  rem_in   = run_len;
                  phase_in = PH_RUN;
               end
            end
         end
         PH_LO: begin
            low_in = in_byte;
            if (end_of_record) begin
               r0       = mk_res(8'd0, KIND_ERR, ERR_TRUNC);
               cnt      = 2'd1;
               do_clear = 1'b1;
            end else begin
               phase_in = PH_HI;
            end
         end
         PH_RUN: begin
            r0     = mk_res(in_byte, KIND_DATA, ERR_NONE);
            cnt    = 2'd1;
            rem_in = rem_dec;
            if (rem_dec == 16'd0) begin
               if (short_ff) begin
                  if (end_of_record) begin
                     r1       = mk_res(8'd0, KIND_DONE, ERR_NONE);
                     cnt      = 2'd2;
                     do_clear = 1'b1;
                  end else begin
                     r1       = mk_res(PAIR_FIRST, KIND_DATA, ERR_NONE);
                     r2       = mk_res(PAIR_SECOND, KIND_DATA, ERR_NONE);
                     cnt      = 2'd3;
                     phase_in = PH_LO;
                  end
               end else if (end_of_record) begin
                  r1       = mk_res(8'd0, KIND_ERR, ERR_TRUNC);
                  cnt      = 2'd2;
                  do_clear = 1'b1;
               end else begin
                  phase_in = PH_LO;
               end
            end else if (end_of_record) begin
               r1       = mk_res(8'd0, KIND_ERR, ERR_TRUNC);
               cnt      = 2'd2;
               do_clear = 1'b1;
            end
         end
         PH_DROP: begin
            if (end_of_record) do_clear = 1'b1;
         end
         default: begin
            do_clear = 1'b1;
         end
      endcase

      if (do_clear) begin
         phase_in = PH_FIRST;
         rem_in   = 16'd0;
         low_in   = 8'd0;
         short_in = 1'b0;
      end

      r0.last = (cnt == 2'd1);
      r1.last = (cnt == 2'd2);
      r2.last = (cnt == 2'd3);
   end

   assign res     = {r2, r1, r0};
   assign res_cnt = cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         rem_ff   <= 16'd0;
         low_ff   <= 8'd0;
         short_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         low_ff   <= low_in;
         short_ff <= short_in;
      end
   end

endmodule

// ----- hw/rtl/wsrd_queue.sv -----
module wsrd_queue import wsrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  res_cnt_type           push_cnt,
   input  res_type [MAX_RES-1:0] push_res,
   input  logic                  pop,
   output logic                  room,
   output logic                  head_valid,
   output res_type               head
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   res_type           mem [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              do_pop;

   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign do_pop     = pop && head_valid;
   assign room       = (count_ff <= (PW+1)'(DEPTH - MAX_RES));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PW'(do_pop);
      count_in  = count_ff + (PW+1)'(push_cnt) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (PW'(i) < PW'(push_cnt)) mem[wr_ptr_ff + PW'(i)] <= push_res[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/word_stuff_record_decoder.sv -----
// An accepted request's results are written into the result queue and offered from
// its head in order. Throughput: one request per cycle while each yields at most one
// result and rsp_ready is high; a request yielding k results fills k entries of the
// 4-entry result queue (requests are taken while it has room for 3 entries).
// Reset: synchronous, active high; clears decode state and empties the queue.
module word_stuff_record_decoder import wsrd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_record,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last_of_item
);

   logic                  accept;
   logic                  room;
   res_type [MAX_RES-1:0] res;
   res_cnt_type           res_cnt;
   res_cnt_type           push_cnt;
   res_type               head;

   assign req_ready = room;
   assign accept    = req_valid && room;
   assign push_cnt  = accept ? res_cnt : 2'd0;

   wsrd_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .end_of_record (req_end_of_record),
      .res           (res),
      .res_cnt       (res_cnt)
   );

   wsrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_res   (res),
      .pop        (rsp_ready),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_out_byte     = head.data;
   assign rsp_kind         = head.kind;
   assign rsp_error_code   = head.code;
   assign rsp_last_of_item = head.last;

endmodule
